>>> hdl/text_content_pattern_classifier_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text content pattern classifier.
// Expect signals named clk and rst_n in the scope of use.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONTENT_PATTERN_CLASSIFIER_UNIT_ASSERT_SVH
`define TEXT_CONTENT_PATTERN_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tcpc_pkg.sv
// ---------------------------------------------------------------------------
// tcpc_pkg
// Shared types, pattern constants and helpers of the text classifier.
// ---------------------------------------------------------------------------
package tcpc_pkg;

  localparam int unsigned HistBytes = 9;
  localparam int unsigned HistW     = 8 * HistBytes;
  localparam int unsigned LenW      = 12;
  localparam int unsigned FlagW     = 7;

  // Flag bit positions
  localparam int unsigned FlagDate  = 0;
  localparam int unsigned FlagTime  = 1;
  localparam int unsigned FlagText  = 2;
  localparam int unsigned FlagCoord = 3;
  localparam int unsigned FlagTemp  = 4;
  localparam int unsigned FlagNum   = 5;
  localparam int unsigned FlagIsbn  = 6;

  // Minimum run length for the text flag
  localparam logic [LenW-1:0] TextMinLen = 12'd8;

  // Masks and patterns over four-byte windows
  localparam logic [31:0] MaskNib4    = 32'hF0F0F0F0;
  localparam logic [31:0] PatNib4     = 32'h30303030;
  localparam logic [31:0] MaskDateA   = 32'hFDF0F0FD;
  localparam logic [31:0] PatDateA    = 32'h2D30302D;
  localparam logic [31:0] MaskDateB   = 32'hF0FDF0FD;
  localparam logic [31:0] PatDateB    = 32'h302D302D;
  localparam logic [31:0] MaskDateC   = 32'hF0F0FDF0;
  localparam logic [31:0] PatDateC    = 32'h30302D30;
  localparam logic [31:0] MaskDateD   = 32'hF0F0F0FD;
  localparam logic [31:0] PatDateD    = 32'h3030302D;
  localparam logic [31:0] MaskDateE   = 32'hF0FDF0F0;
  localparam logic [31:0] PatDateE    = 32'h302D3030;
  localparam logic [31:0] MaskTimeA   = 32'hF0FFF0F0;
  localparam logic [31:0] PatTimeA    = 32'h303A3030;
  localparam logic [31:0] MaskTimeB   = 32'hF0F0FF00;
  localparam logic [31:0] PatTimeB    = 32'h30303A00;
  localparam logic [31:0] MaskTemp    = 32'h00FFFFFA;
  localparam logic [31:0] PatTemp     = 32'h00C2B042;
  localparam logic [31:0] PatIsbn     = 32'h4953424E;
  localparam logic [31:0] MaskHiBit   = 32'h80808080;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChG     = 8'h47;

  // Window held for classification
  typedef struct packed {
    logic [HistW-1:0] hist;  // [7:0] newest byte
    logic [LenW-1:0]  len;
  } tcpc_win_t;

  function automatic logic is_digit(input logic [7:0] v);
    return (v >= 8'h30) && (v <= 8'h39);
  endfunction

endpackage

>>> hdl/tcpc_window.sv
// ---------------------------------------------------------------------------
// tcpc_window
// Input stage: nine-byte shift history plus registered run length.
// ---------------------------------------------------------------------------
module tcpc_window (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic [tcpc_pkg::LenW-1:0] in_len,
  input  logic                  adv,       // downstream takes the held item
  output logic                  win_valid,
  output tcpc_pkg::tcpc_win_t   win
);
  import tcpc_pkg::*;

  logic             valid_r, valid_nxt;
  logic [HistW-1:0] hist_r, hist_nxt;
  logic [LenW-1:0]  len_r;
  logic             take;

  assign in_ready = !valid_r || adv;
  assign take     = in_valid && in_ready;

  // Shift the new byte in at the low end
  always_comb begin
    hist_nxt  = take ? {hist_r[HistW-9:0], in_byte} : hist_r;
    valid_nxt = take ? 1'b1 : (adv ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hist_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      hist_r  <= hist_nxt;
    end
  end

  // Length is payload only
  always_ff @(posedge clk) begin
    if (take) begin
      len_r <= in_len;
    end
  end

  assign win_valid = valid_r;
  assign win.hist  = hist_r;
  assign win.len   = len_r;

endmodule

>>> hdl/tcpc_classify.sv
// ---------------------------------------------------------------------------
// tcpc_classify
// Masked pattern tests over the nine-byte window, giving seven flags.
// ---------------------------------------------------------------------------
module tcpc_classify (
  input  tcpc_pkg::tcpc_win_t          win,
  output logic [tcpc_pkg::FlagW-1:0]   flags
);
  import tcpc_pkg::*;

  logic [31:0] q4, q8;
  logic [7:0]  b1, b4, b5, b9;
  logic        d1, d2, d3, d4, d5, d6, d7, d8, d9;
  logic        date_f, time_f, text_f, temp_f, isbn_f;

  assign q4 = win.hist[31:0];
  assign q8 = win.hist[63:32];
  assign b1 = win.hist[7:0];
  assign b4 = win.hist[31:24];
  assign b5 = win.hist[39:32];
  assign b9 = win.hist[71:64];

  assign d1 = is_digit(win.hist[7:0]);
  assign d2 = is_digit(win.hist[15:8]);
  assign d3 = is_digit(win.hist[23:16]);
  assign d4 = is_digit(win.hist[31:24]);
  assign d5 = is_digit(win.hist[39:32]);
  assign d6 = is_digit(win.hist[47:40]);
  assign d7 = is_digit(win.hist[55:48]);
  assign d8 = is_digit(win.hist[63:56]);
  assign d9 = is_digit(b9);

  // Date: four-digit tail, else four-digit head
  always_comb begin
    if ((q4 & MaskNib4) == PatNib4) begin
      date_f = d1 && d2 && d3 && d4 &&
               ((((q8 & MaskDateA) == PatDateA) && d9) ||
                ((q8 & MaskDateB) == PatDateB));
    end else begin
      date_f = (((q8 & MaskDateC) == PatDateC) || ((q8 & MaskDateD) == PatDateD)) &&
               d9 && d7 && d8 && ((q4 & MaskDateE) == PatDateE);
    end
  end

  // Time hh:mm with guard on the preceding digits
  assign time_f = ((q4 & MaskTimeA) == PatTimeA) && d5 &&
                  (!d6 || (((q8 & MaskTimeB) == PatTimeB) && !d9));

  // Eight bytes of 7-bit text
  assign text_f = (win.len >= TextMinLen) && ((q8 & MaskHiBit) == 32'h0) &&
                  ((q4 & MaskHiBit) == 32'h0);

  // Degree sign then B, C or F
  assign temp_f = ((q4 & MaskTemp) == PatTemp) && (b1 != ChG) &&
                  (d4 || ((b4 == ChSpace) && d5));

  assign isbn_f = (q4 == PatIsbn) && (b5 == ChSpace);

  always_comb begin
    flags            = '0;
    flags[FlagDate]  = date_f;
    flags[FlagTime]  = time_f;
    flags[FlagText]  = text_f;
    flags[FlagCoord] = 1'b0;  // coordinate walk never completes
    flags[FlagTemp]  = temp_f;
    flags[FlagNum]   = d1;
    flags[FlagIsbn]  = isbn_f;
  end

endmodule

>>> hdl/text_content_pattern_classifier_unit.sv
// ---------------------------------------------------------------------------
// text_content_pattern_classifier_unit
// Byte-stream classifier: seven content flags per byte over a 9-byte window.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  channel: one text byte and the current content run length per item.
//   out_* channel: one flag item per input item, in order.
//   An accepted item loads the window register first and moves on to the
//   result register, which drives out_tvalid, when that register can take it.
//   Throughput: one item per clock when out_tready stays high; the window
//   and result registers form a two-stage pipeline.
//   When the receiver stalls, the result register holds its item and the
//   window stage holds one more; in_tready then drops until out_tready
//   returns. The byte history shifts only on an accepted item.
//   Reset (rst_n low, synchronous) clears the history to zero bytes and
//   empties both stages.
//   Flags: bit0 date, bit1 time, bit2 text, bit3 coordinates (always 0),
//   bit4 temperature, bit5 number, bit6 ISBN.
// ---------------------------------------------------------------------------
module text_content_pattern_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [19:8] content_length, [23:20] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [6:0] content_flags, [7] zero
);
  import tcpc_pkg::*;

  tcpc_win_t         win;
  logic              win_valid;
  logic              s2_ready;
  logic [FlagW-1:0]  flags;
  logic              out_valid_r, out_valid_nxt;
  logic [FlagW-1:0]  out_flags_r;

  assign s2_ready = !out_valid_r || out_tready;

  // Window stage
  tcpc_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata[7:0]),
    .in_len    (in_tdata[19:8]),
    .adv       (s2_ready),
    .win_valid (win_valid),
    .win       (win)
  );

  // Pattern logic
  tcpc_classify u_classify (
    .win   (win),
    .flags (flags)
  );

  // Result register
  assign out_valid_nxt = s2_ready ? win_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && win_valid) begin
      out_flags_r <= flags;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_flags_r};

  // Checks
  `include "text_content_pattern_classifier_unit_assert.svh"

  `TCPC_ASSERT_NEXT(a_hist_hold, win_valid && !s2_ready, $stable(win.hist),
    "history moved while stalled")
  `TCPC_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, win_valid, "accepted item not held")
  `TCPC_ASSERT_NEXT(a_num_flag, win_valid && s2_ready,
    out_tdata[FlagNum] == is_digit($past(win.hist[7:0])), "number flag wrong")
  `TCPC_ASSERT_NOW(a_coord_zero, out_tvalid,
    out_tdata[FlagCoord] == 1'b0 && out_tdata[7] == 1'b0, "reserved flag set")

endmodule

>>> test/tb_text_content_pattern_classifier_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_content_pattern_classifier_unit
// Self-checking bench for the text content pattern classifier.
// A short table of directed bytes comes first: reset state, field extremes,
// an ISBN tag, a date, a time and a temperature. Random phrases follow:
// dates, times, temperatures, ISBN tags, text runs, digit runs and noise.
// Every accepted byte is run through a local flag predictor with its own
// nine-byte window. Each result item is compared in order. The sender works
// in bursts and the receiver stalls, with one long hold-off to fill the pipe.
// ---------------------------------------------------------------------------
module tb_text_content_pattern_classifier_unit;
  import tcpc_pkg::*;

  localparam int unsigned RandItems  = 1950;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned DirRows    = 27;

  localparam logic [7:0]  Space   = 8'h20;
  localparam logic [7:0]  Colon   = 8'h3A;
  localparam logic [7:0]  LetterG = 8'h47;
  localparam logic [31:0] IsbnTag = 32'h4953424E;

  // one stimulus row; flags only meaningful when fixed is set
  typedef struct packed {
    logic             fixed;
    logic [FlagW-1:0] flags;
    logic [LenW-1:0]  len;
    logic [7:0]       data;
  } text_item_t;

  // {fixed, flags, content_length, data_byte}
  text_item_t dir_tab [DirRows] = '{
    {1'b1, 7'h00, 12'd0,    8'h00},  // reset window, all zero
    {1'b1, 7'h20, 12'd0,    8'h35},  // lone digit
    {1'b1, 7'h00, 12'd4095, 8'hFF},  // field maxima, high bit kills text
    {1'b0, 7'h00, 12'd1,    8'h20},
    {1'b0, 7'h00, 12'd2,    8'h49},
    {1'b0, 7'h00, 12'd3,    8'h53},
    {1'b0, 7'h00, 12'd4,    8'h42},
    {1'b1, 7'h40, 12'd5,    8'h4E},  // " ISBN", short run
    {1'b0, 7'h00, 12'd4095, 8'h39},  // date "9/12/2024"
    {1'b0, 7'h00, 12'd4095, 8'h2F},
    {1'b0, 7'h00, 12'd4095, 8'h31},
    {1'b0, 7'h00, 12'd4095, 8'h32},
    {1'b0, 7'h00, 12'd4095, 8'h2F},
    {1'b0, 7'h00, 12'd4095, 8'h32},
    {1'b0, 7'h00, 12'd4095, 8'h30},
    {1'b0, 7'h00, 12'd4095, 8'h32},
    {1'b0, 7'h00, 12'd4095, 8'h34},
    {1'b0, 7'h00, 12'd7,    8'h20},  // time " 12:34"
    {1'b0, 7'h00, 12'd7,    8'h31},
    {1'b0, 7'h00, 12'd7,    8'h32},
    {1'b0, 7'h00, 12'd7,    8'h3A},
    {1'b0, 7'h00, 12'd7,    8'h33},
    {1'b0, 7'h00, 12'd7,    8'h34},
    {1'b0, 7'h00, 12'd8,    8'h35},  // temperature "5 degC"
    {1'b0, 7'h00, 12'd8,    8'hC2},
    {1'b0, 7'h00, 12'd8,    8'hB0},
    {1'b0, 7'h00, 12'd8,    8'h43}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = 24'h0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  text_item_t       stim_q [$];
  logic [FlagW-1:0] flags_q [$];
  logic [71:0]      window_bytes = 72'h0;
  logic [FlagW-1:0] want_flags;
  int unsigned      err_cnt      = 0;
  int unsigned      bytes_in     = 0;
  int unsigned      results_seen = 0;
  int unsigned      idle_cycles  = 0;
  int unsigned      len_mode     = 0;

  text_content_pattern_classifier_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic bit dec_digit(input logic [7:0] v);
    return (v >= 8'h30) && (v <= 8'h39);
  endfunction

  // Flags for a nine-byte window, newest byte in bits 7:0
  function automatic logic [FlagW-1:0] classify_window(input logic [71:0] w,
                                                      input logic [LenW-1:0] len);
    logic [31:0]      q4;
    logic [31:0]      q8;
    logic [FlagW-1:0] f;
    q4 = w[31:0];
    q8 = w[63:32];
    f  = '0;
    // date: four-digit tail, else four-digit head
    if ((q4 & 32'hF0F0F0F0) == 32'h30303030) begin
      if (dec_digit(w[7:0]) && dec_digit(w[15:8]) && dec_digit(w[23:16]) &&
          dec_digit(w[31:24]) &&
          (((q8 & 32'hFDF0F0FD) == 32'h2D30302D && dec_digit(w[71:64])) ||
           (q8 & 32'hF0FDF0FD) == 32'h302D302D))
        f[FlagDate] = 1'b1;
    end else if (((q8 & 32'hF0F0FDF0) == 32'h30302D30 ||
                  (q8 & 32'hF0F0F0FD) == 32'h3030302D) && dec_digit(w[71:64])) begin
      if (dec_digit(w[55:48]) && dec_digit(w[63:56]) &&
          (q4 & 32'hF0FDF0F0) == 32'h302D3030)
        f[FlagDate] = 1'b1;
    end
    // time hh:mm, not preceded by a longer digit run
    if ((q4 & 32'hF0FFF0F0) == 32'h303A3030 && dec_digit(w[39:32]) &&
        (!dec_digit(w[47:40]) ||
         ((q8 & 32'hF0F0FF00) == 32'h30303A00 && !dec_digit(w[71:64]))))
      f[FlagTime] = 1'b1;
    // eight bytes of 7-bit text
    if (len >= 8 && (w[63:0] & 64'h8080808080808080) == 64'h0)
      f[FlagText] = 1'b1;
    // degree sign then unit letter
    if ((q4 & 32'h00FFFFFA) == 32'h00C2B042 && w[7:0] != LetterG &&
        (dec_digit(w[31:24]) || (w[31:24] == Space && dec_digit(w[39:32]))))
      f[FlagTemp] = 1'b1;
    if (dec_digit(w[7:0]))
      f[FlagNum] = 1'b1;
    if (q4 == IsbnTag && w[39:32] == Space)
      f[FlagIsbn] = 1'b1;
    return f;
  endfunction

  function automatic logic [7:0] pick_digit();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(8'h3A, 8'h3F))
                                       : 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 7))
      0: return 8'h2C;
      1: return 8'h2E;
      2: return 8'hAD;
      3, 4, 5: return 8'h2D;
      default: return 8'h2F;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    logic [LenW-1:0] len;
    case (len_mode)
      0: len = LenW'($urandom_range(0, 4095));
      1: len = LenW'($urandom_range(0, 15));
      2: len = 12'd4095;
      default: len = LenW'($urandom_range(7, 8));
    endcase
    stim_q.push_back({1'b0, 7'h00, len, b});
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_cnt < 40)
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    err_cnt++;
  endtask

  // Stimulus build, reset, sender and end of run
  initial begin
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    while (stim_q.size() < DirRows + RandItems) begin
      len_mode = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
        end
        2: begin  // d-dd-dddd
          push_byte(pick_digit()); push_byte(pick_sep());
          push_byte(pick_digit()); push_byte(pick_digit()); push_byte(pick_sep());
          repeat (4) push_byte(pick_digit());
        end
        3: begin  // dddd-dd-dd
          repeat (4) push_byte(pick_digit());
          push_byte(pick_sep()); push_byte(pick_digit()); push_byte(pick_digit());
          push_byte(pick_sep()); push_byte(pick_digit()); push_byte(pick_digit());
        end
        4: begin  // [ |d]hh:mm[:ss]
          push_byte($urandom_range(0, 1) ? Space : pick_digit());
          push_byte(pick_digit()); push_byte(pick_digit());
          push_byte(($urandom_range(0, 7) == 0) ? 8'h3B : Colon);
          push_byte(pick_digit()); push_byte(pick_digit());
          if ($urandom_range(0, 1)) begin
            push_byte(Colon); push_byte(pick_digit()); push_byte(pick_digit());
          end
        end
        5: begin  // d[ ] degree unit
          push_byte(pick_digit());
          if ($urandom_range(0, 2) == 0) push_byte(Space);
          push_byte(($urandom_range(0, 7) == 0) ? 8'hC3 : 8'hC2);
          push_byte(8'hB0);
          push_byte(8'($urandom_range(8'h40, 8'h47)));
        end
        6: begin  // ISBN tag
          push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : Space);
          for (int k = 3; k >= 0; k--) push_byte(IsbnTag[8*k +: 8]);
          repeat ($urandom_range(0, 3)) push_byte(pick_digit());
        end
        7, 8: begin  // text run, rare high-bit byte
          repeat ($urandom_range(6, 14))
            push_byte(($urandom_range(0, 15) == 0) ? 8'($urandom_range(128, 255))
                                                   : 8'($urandom_range(32, 126)));
        end
        default: begin
          repeat ($urandom_range(1, 8)) push_byte(pick_digit());
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // bursts of items with random gaps
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      while (burst > 0 && idx < stim_q.size()) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {4'h0, stim_q[idx].len, stim_q[idx].data};
        @(negedge clk);
        while (!in_tready) @(negedge clk);
        @(posedge clk);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    while (flags_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (err_cnt == 0)
      $display("[text_content_pattern_classifier_unit] OK");
    else
      $display("[text_content_pattern_classifier_unit] ERROR");
    $finish;
  end

  // Receiver: ready ratio changes per phase, one long hold-off
  initial begin
    bit          held_off;
    int unsigned ready_pct;
    int unsigned phase_left;
    held_off   = 1'b0;
    ready_pct  = 100;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && !held_off && results_seen >= 400) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if (phase_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1: ready_pct = 100;
          2: ready_pct = 75;
          3: ready_pct = 50;
          default: ready_pct = 20;
        endcase
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      out_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // Handshakes sampled mid-cycle; they complete at the next rising edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        window_bytes = {window_bytes[63:0], in_tdata[7:0]};
        want_flags   = classify_window(window_bytes, in_tdata[19:8]);
        flags_q.push_back(stim_q[bytes_in].fixed ? stim_q[bytes_in].flags : want_flags);
        bytes_in++;
      end
      if (out_tvalid && out_tready) begin
        if (flags_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_tdata, 8'h00);
        end else begin
          want_flags = flags_q.pop_front();
          if (out_tdata !== {1'b0, want_flags})
            report_mismatch($sformatf("flags of result %0d", results_seen),
                            out_tdata, {1'b0, want_flags});
        end
        results_seen++;
      end
      // watchdog on accepted items
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[text_content_pattern_classifier_unit] ERROR");
        $finish;
      end
    end
  end

endmodule

>>> text_content_pattern_classifier_unit.f
+incdir+hdl
hdl/tcpc_pkg.sv
hdl/tcpc_window.sv
hdl/tcpc_classify.sv
hdl/text_content_pattern_classifier_unit.sv
test/tb_text_content_pattern_classifier_unit.sv
